// File: sv/tkvt_pkg.sv
// Package for the tagged key-value table: sizes, operation codes and reset values.
`default_nettype none
package tkvt_pkg;

  localparam int ENTRIES_DEF    = 8;
  localparam int TAGS_DEF       = 4;
  localparam int IN_TAGS        = 4;

  localparam int KEY_W          = 32;
  localparam int TAG_CNT_W      = 3;
  localparam int CAP_W          = 4;
  localparam int OCC_W          = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

endpackage
`default_nettype wire

// File: sv/tkvt_req_if.sv
// Request channel: one table operation per item.
`default_nettype none
interface tkvt_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [31:0] key;
  logic signed [31:0] value;
  logic signed [31:0] tag_a;
  logic signed [31:0] tag_b;
  logic signed [31:0] tag_c;
  logic signed [31:0] tag_d;
  logic        [2:0]  tag_count;
  logic signed [31:0] search_tag;

  modport source (output valid, op, key, value, tag_a, tag_b, tag_c, tag_d,
                  tag_count, search_tag, input ready);
  modport sink   (input valid, op, key, value, tag_a, tag_b, tag_c, tag_d,
                  tag_count, search_tag, output ready);
endinterface
`default_nettype wire

// File: sv/tkvt_rsp_if.sv
// Response channel: one result item per request.
`default_nettype none
interface tkvt_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] found_value;
  logic signed [31:0] found_tag_a;
  logic signed [31:0] found_tag_b;
  logic signed [31:0] found_tag_c;
  logic signed [31:0] found_tag_d;
  logic        [2:0]  found_tag_count;
  logic        [3:0]  occupancy;

  modport source (output valid, ok, found_value, found_tag_a, found_tag_b, found_tag_c,
                  found_tag_d, found_tag_count, occupancy, input ready);
  modport sink   (input valid, ok, found_value, found_tag_a, found_tag_b, found_tag_c,
                  found_tag_d, found_tag_count, occupancy, output ready);
endinterface
`default_nettype wire

// File: sv/tagged_key_value_table.sv
// Tagged key-value table: parallel slot search, one operation per cycle unless stalled.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------------
//  req     | in  | valid/ready   | op, key, value, tag_a..tag_d, tag_count, search_tag
//  rsp     | out | valid/ready   | ok, found_value, found_tag_a..d, found_tag_count,
//          |     |               | occupancy
//  cfg     | in  | cfg_we        | cfg_wdata = capacity
//
// An item is accepted into the input register and is resolved against the slot
// registers on its way into the result register, one item per cycle sustained while
// the result is not stalled. All ENTRIES keys and ENTRIES*TAGS_PER_ENTRY tags are
// compared in parallel in that one step. A stalled result holds the result and input
// registers; an empty input register still takes one more item. Synchronous reset
// empties the table and sets capacity to 8.
`default_nettype none
module tagged_key_value_table
  import tkvt_pkg::*;
#(
  parameter int ENTRIES        = ENTRIES_DEF,
  parameter int TAGS_PER_ENTRY = TAGS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  tkvt_req_if.sink              req,
  tkvt_rsp_if.source            rsp,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int SW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TPW  = (TAGS_PER_ENTRY > 1) ? $clog2(TAGS_PER_ENTRY) : 1;
  localparam int TCW  = $clog2(TAGS_PER_ENTRY + 1);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int LIM  = (TAGS_PER_ENTRY < IN_TAGS) ? TAGS_PER_ENTRY : IN_TAGS;

  // configuration
  logic [CAP_W-1:0] capacity;

  // table
  logic [ENTRIES-1:0] slot_valid;
  logic [ENTRIES-1:0] slot_valid_next;
  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [KEY_W-1:0]   slot_value [ENTRIES];
  logic [KEY_W-1:0]   slot_tags  [ENTRIES][TAGS_PER_ENTRY];
  logic [TCW-1:0]     slot_tag_count [ENTRIES];

  // input register
  logic                 s1_valid;
  logic [1:0]           s1_op;
  logic [KEY_W-1:0]     s1_key;
  logic [KEY_W-1:0]     s1_value;
  logic [KEY_W-1:0]     s1_tag [IN_TAGS];
  logic [TAG_CNT_W-1:0] s1_tag_count;
  logic [KEY_W-1:0]     s1_search_tag;

  // result register
  logic                 out_valid;
  logic                 out_ok;
  logic [KEY_W-1:0]     out_value;
  logic [KEY_W-1:0]     out_tag [IN_TAGS];
  logic [TAG_CNT_W-1:0] out_tag_count;
  logic [OCC_W-1:0]     out_occupancy;

  logic fire;
  logic accept;

  // lookup
  logic [ENTRIES-1:0] key_hit;
  logic [ENTRIES-1:0] tag_hit;
  logic               any_key_hit;
  logic [SW-1:0]      hit_idx;
  logic               any_free;
  logic [SW-1:0]      free_idx;
  logic [CMPW-1:0]    occ;
  logic [CMPW-1:0]    occ_after;
  logic               add_ok;

  // tag set for add
  logic [TAG_CNT_W-1:0] tcnt_sat;
  logic [LIM-1:0]       keep;
  logic [TPW-1:0]       pos [LIM];
  logic [KEY_W-1:0]     new_tags [TAGS_PER_ENTRY];
  logic [TCW-1:0]       new_count;

  // get results
  logic [TCW-1:0]       get_count;
  logic [KEY_W-1:0]     get_tag [IN_TAGS];

  logic                 res_ok;

  assign fire      = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || fire;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op         <= req.op;
      s1_key        <= req.key;
      s1_value      <= req.value;
      s1_tag[0]     <= req.tag_a;
      s1_tag[1]     <= req.tag_b;
      s1_tag[2]     <= req.tag_c;
      s1_tag[3]     <= req.tag_d;
      s1_tag_count  <= req.tag_count;
      s1_search_tag <= req.search_tag;
    end
  end

  always_comb begin
    any_key_hit = 1'b0;
    hit_idx     = '0;
    any_free    = 1'b0;
    free_idx    = '0;
    occ         = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      key_hit[i] = slot_valid[i] && (slot_key[i] == s1_key);
      tag_hit[i] = 1'b0;
      for (int t = 0; t < TAGS_PER_ENTRY; t++) begin
        if (TCW'(t) < slot_tag_count[i] && slot_tags[i][t] == s1_search_tag) begin
          tag_hit[i] = slot_valid[i];
        end
      end
      if (key_hit[i]) begin
        any_key_hit = 1'b1;
        hit_idx     = SW'(i);
      end
      if (!slot_valid[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      occ = occ + CMPW'(slot_valid[i]);
    end
    add_ok = (occ < CMPW'(capacity)) && any_free && !any_key_hit;
  end

  // first occurrence of each tag kept, packed in order
  always_comb begin
    tcnt_sat  = (s1_tag_count > TAG_CNT_W'(LIM)) ? TAG_CNT_W'(LIM) : s1_tag_count;
    new_count = '0;
    for (int p = 0; p < TAGS_PER_ENTRY; p++) begin
      new_tags[p] = '0;
    end
    for (int t = 0; t < LIM; t++) begin
      keep[t] = TAG_CNT_W'(t) < tcnt_sat;
      for (int u = 0; u < t; u++) begin
        if (s1_tag[u] == s1_tag[t]) begin
          keep[t] = 1'b0;
        end
      end
      pos[t] = TPW'(new_count);
      if (keep[t]) begin
        new_tags[pos[t]] = s1_tag[t];
        new_count        = new_count + 1'b1;
      end
    end
  end

  always_comb begin
    get_count = (slot_tag_count[hit_idx] > TCW'(LIM)) ? TCW'(LIM) : slot_tag_count[hit_idx];
    for (int t = 0; t < IN_TAGS; t++) begin
      get_tag[t] = '0;
    end
    for (int t = 0; t < LIM; t++) begin
      if (TCW'(t) < get_count) begin
        get_tag[t] = slot_tags[hit_idx][t];
      end
    end
  end

  always_comb begin
    slot_valid_next = slot_valid;
    res_ok          = 1'b1;
    case (s1_op)
      OP_ADD: begin
        res_ok = add_ok;
        if (add_ok) begin
          slot_valid_next[free_idx] = 1'b1;
        end
      end
      OP_GET: begin
        res_ok = any_key_hit;
      end
      OP_REMOVE: begin
        slot_valid_next = slot_valid & ~tag_hit;
      end
      OP_CLEAR: begin
        slot_valid_next = '0;
      end
      default: begin
        slot_valid_next = slot_valid;
      end
    endcase
    occ_after = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      occ_after = occ_after + CMPW'(slot_valid_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (fire) begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_op == OP_ADD && add_ok) begin
      slot_key[free_idx]       <= s1_key;
      slot_value[free_idx]     <= s1_value;
      slot_tag_count[free_idx] <= new_count;
      for (int p = 0; p < TAGS_PER_ENTRY; p++) begin
        slot_tags[free_idx][p] <= new_tags[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ok        <= res_ok;
      out_occupancy <= occ_after[OCC_W-1:0];
      if (s1_op == OP_GET && any_key_hit) begin
        out_value     <= slot_value[hit_idx];
        out_tag_count <= TAG_CNT_W'(get_count);
        for (int t = 0; t < IN_TAGS; t++) begin
          out_tag[t] <= get_tag[t];
        end
      end else begin
        out_value     <= '0;
        out_tag_count <= '0;
        for (int t = 0; t < IN_TAGS; t++) begin
          out_tag[t] <= '0;
        end
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.ok              = out_ok;
  assign rsp.found_value     = out_value;
  assign rsp.found_tag_a     = out_tag[0];
  assign rsp.found_tag_b     = out_tag[1];
  assign rsp.found_tag_c     = out_tag[2];
  assign rsp.found_tag_d     = out_tag[3];
  assign rsp.found_tag_count = out_tag_count;
  assign rsp.occupancy       = out_occupancy;

endmodule
`default_nettype wire

// File: sv/tkvt_checker.sv
// Port-level checks for the tagged key-value table, bound to the top level.
`default_nettype none
module tkvt_checker
  import tkvt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic                 rsp_ok,
  input wire logic [KEY_W-1:0]     rsp_found_value,
  input wire logic [TAG_CNT_W-1:0] rsp_found_tag_count,
  input wire logic [OCC_W-1:0]     rsp_occupancy
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_occupancy)
      && $stable(rsp_found_value) && $stable(rsp_found_tag_count))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_found_value == '0 && rsp_found_tag_count == '0)
    else $error("failed operation carries found data");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (ENTRIES > 15) || (int'(rsp_occupancy) <= ENTRIES))
    else $error("occupancy above table size");

endmodule

bind tagged_key_value_table tkvt_checker #(.ENTRIES(ENTRIES)) u_tkvt_checker (
  .clk                 (clk),
  .rst                 (rst),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_ok              (rsp.ok),
  .rsp_found_value     (rsp.found_value),
  .rsp_found_tag_count (rsp.found_tag_count),
  .rsp_occupancy       (rsp.occupancy)
);
`default_nettype wire

// File: bench/tagged_key_value_table_tb.sv
// Testbench for the tagged key-value table: directed and random operations, checked item by item.
module tagged_key_value_table_tb;
  import tkvt_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] tag_a;
    logic [31:0] tag_b;
    logic [31:0] tag_c;
    logic [31:0] tag_d;
    logic [2:0]  tag_count;
    logic [31:0] search_tag;
  } table_request_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
    logic [31:0] tag_a;
    logic [31:0] tag_b;
    logic [31:0] tag_c;
    logic [31:0] tag_d;
    logic [2:0]  count;
    logic [3:0]  occupancy;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  tkvt_req_if req();
  tkvt_rsp_if rsp();

  tagged_key_value_table dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  table_result_t pending_results[$];
  table_result_t want;

  // shadow copy of the table
  logic             slot_used [ENTRIES_DEF];
  logic [31:0]      slot_key [ENTRIES_DEF];
  logic [31:0]      slot_value [ENTRIES_DEF];
  logic [31:0]      slot_tag [ENTRIES_DEF][TAGS_DEF];
  int               slot_tag_cnt [ENTRIES_DEF];
  logic [CAP_W-1:0] table_capacity;

  function automatic int occupied_slots();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES_DEF; i++) if (slot_used[i]) n++;
    return n;
  endfunction

  function automatic int lookup_key(logic [31:0] key);
    for (int i = 0; i < ENTRIES_DEF; i++) if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function automatic logic holds_tag(int slot, logic [31:0] tag);
    for (int t = 0; t < slot_tag_cnt[slot]; t++) if (slot_tag[slot][t] == tag) return 1'b1;
    return 1'b0;
  endfunction

  function automatic table_result_t apply_operation(table_request_t it);
    table_result_t r;
    logic [31:0] cand [IN_TAGS];
    logic [31:0] shown [IN_TAGS];
    int free_slot, hit, n, limit;
    r = '0;
    cand = '{it.tag_a, it.tag_b, it.tag_c, it.tag_d};
    shown = '{32'd0, 32'd0, 32'd0, 32'd0};
    case (it.op)
      OP_ADD: begin
        free_slot = -1;
        for (int i = ENTRIES_DEF - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
        if (occupied_slots() < int'(table_capacity) && free_slot >= 0
            && lookup_key(it.key) < 0) begin
          limit = (IN_TAGS < TAGS_DEF) ? IN_TAGS : TAGS_DEF;
          if (int'(it.tag_count) < limit) limit = int'(it.tag_count);
          n = 0;
          slot_tag_cnt[free_slot] = 0;
          for (int t = 0; t < limit; t++) begin
            if (!holds_tag(free_slot, cand[t]) && n < TAGS_DEF) begin
              slot_tag[free_slot][n] = cand[t];
              n++;
              slot_tag_cnt[free_slot] = n;
            end
          end
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot] = it.key;
          slot_value[free_slot] = it.value;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        hit = lookup_key(it.key);
        if (hit >= 0) begin
          n = slot_tag_cnt[hit];
          for (int t = 0; t < n && t < IN_TAGS; t++) shown[t] = slot_tag[hit][t];
          r.ok = 1'b1;
          r.value = slot_value[hit];
          r.count = 3'((n < IN_TAGS) ? n : IN_TAGS);
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < ENTRIES_DEF; i++)
          if (slot_used[i] && holds_tag(i, it.search_tag)) slot_used[i] = 1'b0;
        r.ok = 1'b1;
      end
      default: begin
        for (int i = 0; i < ENTRIES_DEF; i++) slot_used[i] = 1'b0;
        r.ok = 1'b1;
      end
    endcase
    r.tag_a = shown[0];
    r.tag_b = shown[1];
    r.tag_c = shown[2];
    r.tag_d = shown[3];
    r.occupancy = 4'(occupied_slots());
    return r;
  endfunction

  function automatic table_request_t noise_request();
    table_request_t r;
    r.op = 2'($urandom_range(0, 3));
    r.key = $urandom;
    r.value = $urandom;
    r.tag_a = $urandom;
    r.tag_b = $urandom;
    r.tag_c = $urandom;
    r.tag_d = $urandom;
    r.tag_count = 3'($urandom_range(0, 7));
    r.search_tag = $urandom;
    return r;
  endfunction

  function automatic table_request_t add_req(logic [31:0] key, logic [31:0] value,
                                             logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic [31:0] d,
                                             logic [2:0] cnt);
    table_request_t r;
    r = noise_request();
    r.op = OP_ADD;
    r.key = key;
    r.value = value;
    r.tag_a = a;
    r.tag_b = b;
    r.tag_c = c;
    r.tag_d = d;
    r.tag_count = cnt;
    return r;
  endfunction

  function automatic table_request_t get_req(logic [31:0] key);
    table_request_t r;
    r = noise_request();
    r.op = OP_GET;
    r.key = key;
    return r;
  endfunction

  function automatic table_request_t remove_req(logic [31:0] tag);
    table_request_t r;
    r = noise_request();
    r.op = OP_REMOVE;
    r.search_tag = tag;
    return r;
  endfunction

  function automatic table_request_t clear_req();
    table_request_t r;
    r = noise_request();
    r.op = OP_CLEAR;
    return r;
  endfunction

  // small pools so that keys collide and tags are shared between entries
  function automatic logic [31:0] pick_key();
    int k;
    k = $urandom_range(0, 11);
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return 32'h0000_0100 + k;
    endcase
  endfunction

  function automatic logic [31:0] pick_tag();
    int k;
    k = $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (k)
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return k;
    endcase
  endfunction

  function automatic table_request_t traffic_request();
    table_request_t r;
    int roll;
    r = noise_request();
    if ($urandom_range(0, 99) < 88) begin
      roll = $urandom_range(0, 99);
      r.op = (roll < 42) ? OP_ADD : (roll < 80) ? OP_GET : (roll < 97) ? OP_REMOVE : OP_CLEAR;
      r.key = pick_key();
      r.tag_a = pick_tag();
      r.tag_b = pick_tag();
      r.tag_c = pick_tag();
      r.tag_d = pick_tag();
      r.search_tag = pick_tag();
      r.tag_count = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                    : $urandom_range(0, 4));
    end
    return r;
  endfunction

  task automatic send_item(input table_request_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= it.op;
    req.key <= it.key;
    req.value <= it.value;
    req.tag_a <= it.tag_a;
    req.tag_b <= it.tag_b;
    req.tag_c <= it.tag_c;
    req.tag_d <= it.tag_d;
    req.tag_count <= it.tag_count;
    req.search_tag <= it.search_tag;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(apply_operation(it));
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_capacity = cap;
  endtask

  task automatic test_add_get();
    set_capacity(CAP_RESET);
    send_item(add_req(32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'd2, 32'd3, 32'd4, 3'd4));
    // repeated tags collapse to a set
    send_item(add_req(32'h7fff_ffff, 32'h8000_0000, 32'd5, 32'd5, 32'd6, 32'd5, 3'd4));
    send_item(add_req(32'h0, 32'h0, '1, '1, '1, '1, 3'd0));
    // tag count above four saturates
    send_item(add_req('1, '1, 32'd7, 32'd8, 32'd9, 32'd10, 3'd7));
    send_item(add_req(32'h8000_0000, 32'd99, 32'd11, 32'd12, 32'd13, 32'd14, 3'd2));
    send_item(get_req(32'h8000_0000));
    send_item(get_req(32'h7fff_ffff));
    send_item(get_req(32'h0));
    send_item(get_req('1));
    send_item(get_req(32'h0000_1234));
  endtask

  task automatic test_remove_clear();
    send_item(remove_req(32'd5));
    send_item(get_req(32'h7fff_ffff));
    send_item(remove_req(32'hdead_beef));
    send_item(add_req(32'h0000_1234, 32'h55aa_55aa, 32'd1, 32'd0, 32'd0, 32'd0, 3'd1));
    send_item(get_req(32'h0000_1234));
    send_item(remove_req(32'd1));
    send_item(clear_req());
    send_item(get_req('1));
  endtask

  task automatic test_capacity_limits();
    set_capacity(4'd0);
    send_item(add_req(32'h55, 32'h1, 32'd1, 32'd2, 32'd3, 32'd4, 3'd4));
    // capacity above the table size: the ninth add finds no free slot
    set_capacity(4'd15);
    for (int k = 0; k < ENTRIES_DEF + 1; k++)
      send_item(add_req(32'd100 + k, ~k, k, k + 1, k, k + 2, 3'(k % 5)));
    // lowered below occupancy: adds fail, nothing is dropped
    set_capacity(4'd2);
    send_item(add_req(32'h66, 32'h2, 32'd1, 32'd2, 32'd3, 32'd4, 3'd4));
    send_item(get_req(32'd107));
    send_item(clear_req());
  endtask

  task automatic test_random_traffic(input int items, input int src_pct, input int sink_pct,
                                     input logic [CAP_W-1:0] cap);
    set_capacity(cap);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    repeat (items) send_item(traffic_request());
  endtask

  always @(posedge clk) rsp.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none got ok %0b occupancy %0d",
                 $time, rsp.ok, rsp.occupancy);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(rsp.ok));
        check_field("found_value", want.value, rsp.found_value);
        check_field("found_tag_a", want.tag_a, rsp.found_tag_a);
        check_field("found_tag_b", want.tag_b, rsp.found_tag_b);
        check_field("found_tag_c", want.tag_c, rsp.found_tag_c);
        check_field("found_tag_d", want.tag_d, rsp.found_tag_d);
        check_field("found_tag_count", 32'(want.count), 32'(rsp.found_tag_count));
        check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tagged_key_value_table: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      slot_used[i] = 1'b0;
      slot_tag_cnt[i] = 0;
    end
    table_capacity = CAP_RESET;
    req.valid <= 1'b0;
    req.op <= OP_ADD;
    req.key <= '0;
    req.value <= '0;
    req.tag_a <= '0;
    req.tag_b <= '0;
    req.tag_c <= '0;
    req.tag_d <= '0;
    req.tag_count <= '0;
    req.search_tag <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_add_get();
    test_remove_clear();
    test_capacity_limits();
    test_random_traffic(500, 0, 0, CAP_RESET);
    test_random_traffic(500, 77, 0, 4'd15);
    test_random_traffic(500, 0, 77, 4'($urandom_range(1, 7)));
    test_random_traffic(500, 9, 9, 4'd6);

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tagged_key_value_table: match");
    end else begin
      $display("tagged_key_value_table: mismatch");
    end
    $finish;
  end

endmodule
